/* rtl/tked_pkg.sv */
// types and constants shared by the terminal key escape decoder
`default_nettype none

package tked_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned KindW = 4;

  localparam logic [ByteW-1:0] CH_ESC   = 8'h1B;
  localparam logic [ByteW-1:0] CH_LBR   = 8'h5B;
  localparam logic [ByteW-1:0] CH_TILDE = 8'h7E;
  localparam logic [ByteW-1:0] CH_O     = 8'h4F;
  localparam logic [ByteW-1:0] CH_0     = 8'h30;
  localparam logic [ByteW-1:0] CH_1     = 8'h31;
  localparam logic [ByteW-1:0] CH_3     = 8'h33;
  localparam logic [ByteW-1:0] CH_4     = 8'h34;
  localparam logic [ByteW-1:0] CH_5     = 8'h35;
  localparam logic [ByteW-1:0] CH_6     = 8'h36;
  localparam logic [ByteW-1:0] CH_9     = 8'h39;
  localparam logic [ByteW-1:0] CH_A     = 8'h41;
  localparam logic [ByteW-1:0] CH_B     = 8'h42;
  localparam logic [ByteW-1:0] CH_C     = 8'h43;
  localparam logic [ByteW-1:0] CH_D     = 8'h44;
  localparam logic [ByteW-1:0] CH_H     = 8'h48;
  localparam logic [ByteW-1:0] CH_F     = 8'h46;

  localparam logic CMD_BYTE    = 1'b0;
  localparam logic CMD_TIMEOUT = 1'b1;

  localparam logic [KindW-1:0] KEY_CHAR  = 4'd0;
  localparam logic [KindW-1:0] KEY_UP    = 4'd1;
  localparam logic [KindW-1:0] KEY_DOWN  = 4'd2;
  localparam logic [KindW-1:0] KEY_RIGHT = 4'd3;
  localparam logic [KindW-1:0] KEY_LEFT  = 4'd4;
  localparam logic [KindW-1:0] KEY_DEL   = 4'd5;
  localparam logic [KindW-1:0] KEY_HOME  = 4'd6;
  localparam logic [KindW-1:0] KEY_END   = 4'd7;
  localparam logic [KindW-1:0] KEY_PGUP  = 4'd8;
  localparam logic [KindW-1:0] KEY_PGDN  = 4'd9;

  typedef enum logic [3:0] {
    PH_IDLE = 4'b0001,
    PH_ESC  = 4'b0010,
    PH_SEQ  = 4'b0100,
    PH_NUM  = 4'b1000
  } phase_t;

  typedef struct packed {
    logic             emit;
    logic [KindW-1:0] kind;
    logic [ByteW-1:0] ch;
  } key_res_t;

endpackage

`default_nettype wire

/* rtl/terminal_key_escape_decoder_unit.sv */
// top level of the terminal key escape decoder
//
// channel  dir  tdata            tuser         tlast
// in_      in   [7:0] rx_byte    [0] command   -
// out_     out  [7:0] char_value [3:0] key_kind -
//
// one request accepted per cycle while the result side is not stalled; a result,
// when the request yields one, passes through the input register and the result register
// around a single decode pass
// synchronous active-low reset returns the decoder to idle with nothing pending
// a stalled result holds the result register, and the input register then
// holds one more request before in_tready drops
`default_nettype none

module terminal_key_escape_decoder_unit (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [tked_pkg::ByteW-1:0]   in_tdata,   // [7:0] rx_byte
  input  logic                         in_tuser,   // [0] command
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [tked_pkg::ByteW-1:0]   out_tdata,  // [7:0] char_value
  output logic [tked_pkg::KindW-1:0]   out_tuser   // [3:0] key_kind
);
  import tked_pkg::*;

  logic             in_v_r, in_v_nxt;
  logic             cmd_r;
  logic [ByteW-1:0] byte_r;
  logic             adv;
  key_res_t         res;

  assign adv       = in_v_r && (!out_tvalid || out_tready);
  assign in_tready = !in_v_r || adv;

  always_comb begin
    in_v_nxt = in_v_r;
    if (in_tvalid && in_tready) begin
      in_v_nxt = 1'b1;
    end else if (adv) begin
      in_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else begin
      in_v_r <= in_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      cmd_r  <= in_tuser;
      byte_r <= in_tdata;
    end
  end

  tked_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (adv),
    .cmd     (cmd_r),
    .rx_byte (byte_r),
    .res     (res)
  );

  tked_out_reg u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (adv),
    .res        (res),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_kind   (out_tuser),
    .out_ch     (out_tdata)
  );

  // named keys carry no character
  a_key_no_char: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser != KEY_CHAR) |-> out_tdata == '0)
    else $error("named key with nonzero character");

  // key code stays within the defined keys
  a_key_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tuser <= KEY_PGDN)
    else $error("key code out of range");

  // nothing pending after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> (!out_tvalid && in_tready))
    else $error("result or request pending after reset");

  // a timeout request never yields an ordinary character other than escape
  a_timeout_esc: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && cmd_r == CMD_TIMEOUT && res.emit) |-> (res.kind == KEY_CHAR && res.ch == CH_ESC))
    else $error("timeout produced something other than escape");

endmodule

`default_nettype wire

/* rtl/tked_core.sv */
// sequence state and key decode for one request per cycle while step_en is high
`default_nettype none

module tked_core (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     step_en,
  input  logic                     cmd,
  input  logic [tked_pkg::ByteW-1:0] rx_byte,
  output tked_pkg::key_res_t       res
);
  import tked_pkg::*;

  phase_t           phase_r, phase_nxt;
  logic [ByteW-1:0] held_r, held_nxt;

  always_comb begin
    res       = '{emit: 1'b0, kind: KEY_CHAR, ch: '0};
    phase_nxt = phase_r;
    held_nxt  = held_r;
    if (cmd == CMD_TIMEOUT) begin
      if (phase_r != PH_IDLE) begin
        res       = '{emit: 1'b1, kind: KEY_CHAR, ch: CH_ESC};
        phase_nxt = PH_IDLE;
      end
    end else begin
      unique case (phase_r)
        PH_IDLE: begin
          if (rx_byte == CH_ESC) begin
            phase_nxt = PH_ESC;
          end else begin
            res = '{emit: 1'b1, kind: KEY_CHAR, ch: rx_byte};
          end
        end
        PH_ESC: begin
          held_nxt  = rx_byte;
          phase_nxt = PH_SEQ;
        end
        PH_SEQ: begin
          phase_nxt = PH_IDLE;
          res       = '{emit: 1'b1, kind: KEY_CHAR, ch: CH_ESC};
          if (held_r == CH_LBR) begin
            if (rx_byte >= CH_0 && rx_byte <= CH_9) begin
              held_nxt  = rx_byte;
              phase_nxt = PH_NUM;
              res.emit  = 1'b0;
            end else begin
              unique case (rx_byte)
                CH_A:    res = '{emit: 1'b1, kind: KEY_UP,    ch: '0};
                CH_B:    res = '{emit: 1'b1, kind: KEY_DOWN,  ch: '0};
                CH_C:    res = '{emit: 1'b1, kind: KEY_RIGHT, ch: '0};
                CH_D:    res = '{emit: 1'b1, kind: KEY_LEFT,  ch: '0};
                CH_H:    res = '{emit: 1'b1, kind: KEY_HOME,  ch: '0};
                CH_F:    res = '{emit: 1'b1, kind: KEY_END,   ch: '0};
                default: res = '{emit: 1'b1, kind: KEY_CHAR,  ch: CH_ESC};
              endcase
            end
          end else if (held_r == CH_O) begin
            if (rx_byte == CH_H) begin
              res = '{emit: 1'b1, kind: KEY_HOME, ch: '0};
            end else if (rx_byte == CH_F) begin
              res = '{emit: 1'b1, kind: KEY_END, ch: '0};
            end
          end
        end
        PH_NUM: begin
          phase_nxt = PH_IDLE;
          res       = '{emit: 1'b1, kind: KEY_CHAR, ch: CH_ESC};
          if (rx_byte == CH_TILDE) begin
            unique case (held_r)
              CH_1:    res = '{emit: 1'b1, kind: KEY_HOME, ch: '0};
              CH_3:    res = '{emit: 1'b1, kind: KEY_DEL,  ch: '0};
              CH_4:    res = '{emit: 1'b1, kind: KEY_END,  ch: '0};
              CH_5:    res = '{emit: 1'b1, kind: KEY_PGUP, ch: '0};
              CH_6:    res = '{emit: 1'b1, kind: KEY_PGDN, ch: '0};
              default: res = '{emit: 1'b1, kind: KEY_CHAR, ch: CH_ESC};
            endcase
          end
        end
        default: begin
          phase_nxt = PH_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      held_r  <= '0;
    end else if (step_en) begin
      phase_r <= phase_nxt;
      held_r  <= held_nxt;
    end
  end

endmodule

`default_nettype wire

/* rtl/tked_out_reg.sv */
// result register that holds a key until the downstream side takes it
`default_nettype none

module tked_out_reg (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       load,
  input  tked_pkg::key_res_t         res,
  input  logic                       out_tready,
  output logic                       out_tvalid,
  output logic [tked_pkg::KindW-1:0] out_kind,
  output logic [tked_pkg::ByteW-1:0] out_ch
);
  import tked_pkg::*;

  logic             out_v_r, out_v_nxt;
  logic [KindW-1:0] kind_r;
  logic [ByteW-1:0] ch_r;

  always_comb begin
    out_v_nxt = out_v_r;
    if (load) begin
      out_v_nxt = res.emit;
    end else if (out_tready) begin
      out_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else begin
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load && res.emit) begin
      kind_r <= res.kind;
      ch_r   <= res.ch;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_kind   = kind_r;
  assign out_ch     = ch_r;

endmodule

`default_nettype wire
